### rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL files that carry checks.
// Every macro samples on the rising edge of clock and stays quiet while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define CBRF_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define CBRF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/cbrf_pkg.sv
package cbrf_pkg;

   // Fixed point format and step cap
   localparam int unsigned FRAC_BITS = 24;
   localparam int unsigned MAX_STEPS = 48;

   // Field widths
   localparam int unsigned VAL_W    = 32;
   localparam int unsigned TOL_W    = 31;
   localparam int unsigned STEP_W   = 6;

   // Shared multiplier: one 32-bit digit (plus sign) times the 32-bit abscissa
   localparam int unsigned DIG_W    = 32;
   localparam int unsigned DIG_SH   = $clog2(DIG_W);
   localparam int unsigned MUL_W    = DIG_W + 1 + VAL_W;
   localparam int unsigned OPND_W   = 3 * DIG_W;
   localparam int unsigned ACC_W    = OPND_W + 2;

   // Digit index of the signed top digit in each multiply pass
   localparam logic [1:0] P1_TOP_IDX = 2'd1;
   localparam logic [1:0] P2_TOP_IDX = 2'd2;

   localparam logic [TOL_W-1:0]  TOL_RESET     = TOL_W'(1678);

   typedef enum logic [1:0] {
      STATUS_CONVERGED      = 2'd0,
      STATUS_NO_SIGN_CHANGE = 2'd1,
      STATUS_STEP_CAP       = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] low_end;
      logic signed [VAL_W-1:0] high_end;
   } req_payload_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] root;
      status_type              status;
      logic [STEP_W-1:0]       step_count;
   } rsp_payload_type;

   // Controller to polynomial unit
   typedef struct packed {
      logic                    start;
      logic signed [VAL_W-1:0] x;
   } eval_cmd_type;

   // Polynomial unit to controller
   typedef struct packed {
      logic done;
      logic neg;
      logic zero;
   } eval_res_type;

endpackage

### rtl/core/cbrf_chan_if.sv
interface cbrf_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/cbrf_poly_eval.sv
module cbrf_poly_eval #(
   parameter int unsigned FRAC_BITS = cbrf_pkg::FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cbrf_pkg::eval_cmd_type cmd,
   output cbrf_pkg::eval_res_type res
);
   import cbrf_pkg::*;

   // Polynomial constants scaled by 2^F, 2^(2F) and 2^(3F)
   localparam logic [VAL_W:0]   ONE_X   = (VAL_W + 1)'(1) << FRAC_BITS;
   localparam logic [ACC_W-1:0] INIT_P1 = ACC_W'(0) - (ACC_W'(1) << (2 * FRAC_BITS));
   localparam logic [ACC_W-1:0] INIT_P2 = ACC_W'(0) - (ACC_W'(1) << (3 * FRAC_BITS - 1));

   typedef enum logic [1:0] {
      E_IDLE,
      E_ISSUE,
      E_ADD
   } state_type;

   state_type               state_ff, state_in;
   logic signed [VAL_W-1:0] x_ff, x_in;
   logic [OPND_W-1:0]       m_ff, m_in;
   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic signed [MUL_W-1:0] prod_ff, prod_in;
   logic                    prod_vld_ff, prod_vld_in;
   logic [1:0]              pidx_ff, pidx_in;
   logic [1:0]              idx_ff, idx_in;
   logic                    pass_ff, pass_in;
   eval_res_type            res_ff, res_in;

   logic [DIG_W-1:0]        digit;
   logic                    top_digit;
   logic signed [DIG_W:0]   mul_a;
   logic [ACC_W-1:0]        addend;
   logic [ACC_W-1:0]        sum;
   logic [VAL_W:0]          t1;

   // Select the current digit; only the top digit of a pass carries sign
   always_comb begin
      digit     = m_ff[{idx_ff, DIG_SH'(0)} +: DIG_W];
      top_digit = pass_ff ? (idx_ff == P2_TOP_IDX) : (idx_ff == P1_TOP_IDX);
      mul_a     = signed'({top_digit & digit[DIG_W-1], digit});
      prod_in   = MUL_W'(mul_a) * MUL_W'(x_ff);
   end

   // Align the registered partial product and accumulate
   always_comb begin
      addend = '0;
      if (prod_vld_ff) begin
         addend = {{(ACC_W-MUL_W){prod_ff[MUL_W-1]}}, prod_ff} << {pidx_ff, DIG_SH'(0)};
      end
      sum = acc_ff + addend;
      t1  = {cmd.x[VAL_W-1], cmd.x} + ONE_X;
   end

   // Sequence two multiply passes: (x + 1) * x - 1, then that times x - 1/2
   always_comb begin
      state_in    = state_ff;
      x_in        = x_ff;
      m_in        = m_ff;
      acc_in      = acc_ff;
      prod_vld_in = 1'b0;
      pidx_in     = pidx_ff;
      idx_in      = idx_ff;
      pass_in     = pass_ff;
      res_in      = res_ff;
      res_in.done = 1'b0;
      unique case (state_ff)
         E_IDLE: begin
            if (cmd.start) begin
               x_in     = cmd.x;
               m_in     = {{(OPND_W-VAL_W-1){t1[VAL_W]}}, t1};
               acc_in   = INIT_P1;
               pass_in  = 1'b0;
               idx_in   = '0;
               state_in = E_ISSUE;
            end
         end
         E_ISSUE: begin
            acc_in      = sum;
            prod_vld_in = 1'b1;
            pidx_in     = idx_ff;
            if (top_digit) begin
               state_in = E_ADD;
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end
         E_ADD: begin
            if (!pass_ff) begin
               m_in     = sum[OPND_W-1:0];
               acc_in   = INIT_P2;
               pass_in  = 1'b1;
               idx_in   = '0;
               state_in = E_ISSUE;
            end else begin
               acc_in      = sum;
               res_in.done = 1'b1;
               res_in.neg  = sum[ACC_W-1];
               res_in.zero = (sum == '0);
               state_in    = E_IDLE;
            end
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= E_IDLE;
         prod_vld_ff <= 1'b0;
         res_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         prod_vld_ff <= prod_vld_in;
         res_ff      <= res_in;
      end
      x_ff    <= x_in;
      m_ff    <= m_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      pidx_ff <= pidx_in;
      idx_ff  <= idx_in;
      pass_ff <= pass_in;
   end

   assign res = res_ff;

endmodule

### rtl/core/cubic_bisection_root_finder_top.sv
// Termination: the search ends when the width test fails, when a midpoint evaluates to zero
//   or when the step cap is reached.
// Throughput: one item at a time; each polynomial evaluation runs on the one
//   shared 33x32 multiplier (five digit products in two passes).
// Reset: synchronous, active high; returns to idle, drops any pending response, tolerance 1678.
`include "assert_macros.svh"

module cubic_bisection_root_finder_top #(
   parameter int unsigned MAX_STEPS = cbrf_pkg::MAX_STEPS,
   parameter int unsigned FRAC_BITS = cbrf_pkg::FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [cbrf_pkg::TOL_W-1:0]    csr_wr_data,
   cbrf_chan_if.sink                     req_if,
   cbrf_chan_if.source                   rsp_if
);
   import cbrf_pkg::*;

   localparam logic [STEP_W-1:0] MAX_STEP_CNT = STEP_W'(MAX_STEPS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL_LO,
      S_EVAL_HI,
      S_CHECK,
      S_EVAL_MID,
      S_MID,
      S_FINISH
   } state_type;

   state_type               state_ff, state_in;
   logic [TOL_W-1:0]        tol_ff;
   logic signed [VAL_W-1:0] a_ff, a_in;
   logic signed [VAL_W-1:0] b_ff, b_in;
   logic signed [VAL_W-1:0] c_ff, c_in;
   logic                    sa_neg_ff, sa_neg_in;
   logic                    sa_zero_ff, sa_zero_in;
   logic [STEP_W-1:0]       steps_ff, steps_in;
   logic signed [VAL_W-1:0] fin_root_ff, fin_root_in;
   status_type              fin_status_ff, fin_status_in;
   eval_cmd_type            cmd_ff, cmd_in;
   logic                    rsp_vld_ff, rsp_vld_in;
   rsp_payload_type         rsp_data_ff, rsp_data_in;

   eval_res_type            eval_res;
   logic [VAL_W:0]          width;
   logic                    width_ok;
   logic                    req_xfer;
   logic                    eval_wait;
   logic                    rsp_cap;
   logic                    rsp_no_change;
   logic                    rsp_fields_zero;

   function automatic logic signed [VAL_W-1:0] midpoint(
      input logic signed [VAL_W-1:0] lo,
      input logic signed [VAL_W-1:0] hi
   );
      logic [VAL_W:0] s;
      s = {lo[VAL_W-1], lo} + {hi[VAL_W-1], hi};
      return s[VAL_W:1];
   endfunction

   cbrf_poly_eval #(
      .FRAC_BITS (FRAC_BITS)
   ) u_eval (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd_ff),
      .res   (eval_res)
   );

   // Keep halving while high - low >= tolerance; a reversed interval never qualifies
   always_comb begin
      width    = {b_ff[VAL_W-1], b_ff} - {a_ff[VAL_W-1], a_ff};
      width_ok = !width[VAL_W] && (width[VAL_W-1:0] >= {1'b0, tol_ff});
      req_xfer = req_if.valid && req_if.ready;
   end

   assign req_if.ready   = (state_ff == S_IDLE);
   assign rsp_if.valid   = rsp_vld_ff;
   assign rsp_if.payload = rsp_data_ff;

   // Bisection sequencer
   always_comb begin
      state_in      = state_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      c_in          = c_ff;
      sa_neg_in     = sa_neg_ff;
      sa_zero_in    = sa_zero_ff;
      steps_in      = steps_ff;
      fin_root_in   = fin_root_ff;
      fin_status_in = fin_status_ff;
      cmd_in        = cmd_ff;
      cmd_in.start  = 1'b0;
      rsp_vld_in    = rsp_vld_ff;
      rsp_data_in   = rsp_data_ff;

      // Drop the response once transferred
      if (rsp_vld_ff && rsp_if.ready) begin
         rsp_vld_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               a_in         = req_if.payload.low_end;
               b_in         = req_if.payload.high_end;
               steps_in     = '0;
               cmd_in.start = 1'b1;
               cmd_in.x     = req_if.payload.low_end;
               state_in     = S_EVAL_LO;
            end
         end
         S_EVAL_LO: begin
            if (eval_res.done) begin
               sa_neg_in    = eval_res.neg;
               sa_zero_in   = eval_res.zero;
               cmd_in.start = 1'b1;
               cmd_in.x     = b_ff;
               state_in     = S_EVAL_HI;
            end
         end
         S_EVAL_HI: begin
            if (eval_res.done) begin
               if (sa_zero_ff || eval_res.zero || (sa_neg_ff == eval_res.neg)) begin
                  fin_root_in   = '0;
                  fin_status_in = STATUS_NO_SIGN_CHANGE;
                  state_in      = S_FINISH;
               end else begin
                  c_in     = midpoint(a_ff, b_ff);
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (width_ok) begin
               cmd_in.start = 1'b1;
               cmd_in.x     = c_ff;
               state_in     = S_EVAL_MID;
            end else begin
               fin_root_in   = c_ff;
               fin_status_in = STATUS_CONVERGED;
               state_in      = S_FINISH;
            end
         end
         S_EVAL_MID: begin
            if (eval_res.done) begin
               priority if (eval_res.zero) begin
                  fin_root_in   = c_ff;
                  fin_status_in = STATUS_CONVERGED;
                  state_in      = S_FINISH;
               end else if (steps_ff >= MAX_STEP_CNT) begin
                  fin_root_in   = c_ff;
                  fin_status_in = STATUS_STEP_CAP;
                  state_in      = S_FINISH;
               end else begin
                  // Keep the half whose ends still differ in sign
                  if (eval_res.neg != sa_neg_ff) begin
                     b_in = c_ff;
                  end else begin
                     a_in = c_ff;
                  end
                  steps_in = steps_ff + STEP_W'(1);
                  state_in = S_MID;
               end
            end
         end
         S_MID: begin
            c_in     = midpoint(a_ff, b_ff);
            state_in = S_CHECK;
         end
         S_FINISH: begin
            // Hold until the output register is free
            if (!rsp_vld_ff || rsp_if.ready) begin
               rsp_vld_in             = 1'b1;
               rsp_data_in.root       = fin_root_ff;
               rsp_data_in.status     = fin_status_ff;
               rsp_data_in.step_count =
                  (fin_status_ff == STATUS_NO_SIGN_CHANGE) ? '0 : steps_ff;
               state_in               = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         tol_ff     <= TOL_RESET;
         cmd_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cmd_ff     <= cmd_in;
         rsp_vld_ff <= rsp_vld_in;
         if (csr_wr_en) begin
            tol_ff <= csr_wr_data;
         end
      end
      a_ff          <= a_in;
      b_ff          <= b_in;
      c_ff          <= c_in;
      sa_neg_ff     <= sa_neg_in;
      sa_zero_ff    <= sa_zero_in;
      steps_ff      <= steps_in;
      fin_root_ff   <= fin_root_in;
      fin_status_ff <= fin_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // Decode wait states and response kinds for the checks
   always_comb begin
      eval_wait       = (state_ff == S_EVAL_LO) || (state_ff == S_EVAL_HI) ||
                        (state_ff == S_EVAL_MID);
      rsp_cap         = rsp_vld_ff && (rsp_data_ff.status == STATUS_STEP_CAP);
      rsp_no_change   = rsp_vld_ff && (rsp_data_ff.status == STATUS_NO_SIGN_CHANGE);
      rsp_fields_zero = (rsp_data_ff.root == '0) && (rsp_data_ff.step_count == '0);
   end

   // Checks
   `CBRF_ASSERT_NEXT(a_req_starts_eval, req_xfer, cmd_ff.start, "no evaluation after request")
   `CBRF_ASSERT_SAME(a_done_while_waiting, eval_res.done, eval_wait, "done outside a wait state")
   `CBRF_ASSERT_SAME(a_cap_count, rsp_cap, rsp_data_ff.step_count == MAX_STEP_CNT, "bad cap count")
   `CBRF_ASSERT_SAME(a_no_change_zero, rsp_no_change, rsp_fields_zero, "no sign change not zero")

endmodule
